// ----- rtl/cffa_pkg.sv -----
// Package for the circular first-fit assignment block.
// Holds sizes, codes, state and struct types shared by all modules; no dependencies.
package cffa_pkg;

    localparam int MAX_MACHINES = 16;
    localparam int IDX_W        = $clog2(MAX_MACHINES);
    localparam int N_W          = $clog2(MAX_MACHINES + 1);
    localparam int AMT_W        = 24;
    localparam int CAP_W        = 32;
    localparam int CNT_W        = 16;
    localparam int ACT_W        = 5;
    localparam int OUT_IDX_W    = 4;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(16);
    localparam logic             ACTION_LOAD  = 1'b0;
    localparam logic             ACTION_JOB   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    typedef struct packed {
        logic                    cap_we;
        logic                    cnt_we;
        logic [IDX_W-1:0]        addr;
        logic signed [CAP_W-1:0] cap;
        logic [CNT_W-1:0]        cnt;
    } t_bank_wr;

endpackage

// ----- rtl/cffa_bank.sv -----
// Per-machine capacity and job count registers with one shared read address.
// Depends on cffa_pkg.
module cffa_bank
    import cffa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_bank_wr                i_wr,
    input  logic [IDX_W-1:0]        i_rd_addr,
    output logic signed [CAP_W-1:0] o_rd_cap,
    output logic [CNT_W-1:0]        o_rd_cnt
);

    logic signed [CAP_W-1:0] r_cap [MAX_MACHINES];
    logic [CNT_W-1:0]        r_cnt [MAX_MACHINES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_MACHINES; i++) begin
                r_cap[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_wr.cap_we) begin
                r_cap[i_wr.addr] <= i_wr.cap;
            end
            if (i_wr.cnt_we) begin
                r_cnt[i_wr.addr] <= i_wr.cnt;
            end
        end
    end

    assign o_rd_cap = r_cap[i_rd_addr];
    assign o_rd_cnt = r_cnt[i_rd_addr];

endmodule

// ----- rtl/cffa_scan.sv -----
// Shared compare unit of the scan: fit test and running best-capacity tracker.
// Depends on cffa_pkg.
module cffa_scan
    import cffa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_scan_ctl               i_ctl,
    input  logic [AMT_W-1:0]        i_amount,
    input  logic signed [CAP_W-1:0] i_cap,
    input  logic [IDX_W-1:0]        i_pos,
    output logic                    o_hit,
    output logic                    o_fit,
    output logic [IDX_W-1:0]        o_pick
);

    logic                    r_fit;
    logic                    r_first;
    logic signed [CAP_W-1:0] r_best;
    logic [IDX_W-1:0]        r_pick;
    logic signed [CAP_W:0]   amt_ext;
    logic signed [CAP_W:0]   cap_ext;

    assign amt_ext = $signed({{(CAP_W + 1 - AMT_W){1'b0}}, i_amount});
    assign cap_ext = $signed({i_cap[CAP_W-1], i_cap});
    assign o_hit   = (amt_ext <= cap_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit   <= 1'b0;
            r_first <= 1'b1;
            r_pick  <= '0;
        end else if (i_ctl.clear) begin
            r_fit   <= 1'b0;
            r_first <= 1'b1;
        end else if (i_ctl.step) begin
            r_first <= 1'b0;
            if (o_hit) begin
                r_fit  <= 1'b1;
                r_pick <= i_pos;
            end else if (r_first || (i_cap > r_best)) begin
                r_pick <= i_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && (r_first || (i_cap > r_best))) begin
            r_best <= i_cap;
        end
    end

    assign o_fit  = r_fit;
    assign o_pick = r_pick;

endmodule

// ----- rtl/circular_first_fit_assign.sv -----
// A job scans 1..active machines; its result is then registered in the update state.
// A new job or load is accepted only in idle, so jobs do not overlap; a load leaves it idle.
// The scan reads one machine per cycle; a stalled result holds the update of the next job.
// Synchronous active-low reset: capacities and counts zero, scan start 0, active count 16.
// Top level: sequencer, update arithmetic and output register; uses cffa_pkg,
// cffa_bank and cffa_scan.
module circular_first_fit_assign
    import cffa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [ACT_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_action,
    input  logic [3:0]              i_machine_index,
    input  logic [AMT_W-1:0]        i_amount,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [OUT_IDX_W-1:0]    o_assigned_machine,
    output logic                    o_fitted,
    output logic signed [CAP_W-1:0] o_capacity_left,
    output logic [CNT_W-1:0]        o_jobs_on_machine
);

    t_state r_state, n_state;

    logic [ACT_W-1:0]        r_active;
    logic [IDX_W-1:0]        r_scan_start, n_scan_start;
    logic [AMT_W-1:0]        r_amount;
    logic [N_W-1:0]          r_n, n_n;
    logic [IDX_W-1:0]        r_pos, n_pos;
    logic [IDX_W-1:0]        r_iter, n_iter;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_IDX_W-1:0]    r_out_idx;
    logic                    r_out_fit;
    logic signed [CAP_W-1:0] r_out_cap;
    logic [CNT_W-1:0]        r_out_cnt;

    logic                    in_accept;
    logic                    out_take;
    logic                    out_load;
    logic [N_W-1:0]          act_n;
    logic [N_W-1:0]          pos_inc;
    logic                    last_iter;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [CAP_W-1:0] rd_cap;
    logic [CNT_W-1:0]        rd_cnt;
    logic signed [CAP_W:0]   diff;
    logic signed [CAP_W-1:0] left;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    hit;
    logic                    fit;
    logic [IDX_W-1:0]        pick;
    t_scan_ctl               scan_ctl;
    t_bank_wr                bank_wr;

    cffa_bank u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (bank_wr),
        .i_rd_addr (rd_addr),
        .o_rd_cap  (rd_cap),
        .o_rd_cnt  (rd_cnt)
    );

    cffa_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (scan_ctl),
        .i_amount (r_amount),
        .i_cap    (rd_cap),
        .i_pos    (r_pos),
        .o_hit    (hit),
        .o_fit    (fit),
        .o_pick   (pick)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    always_comb begin
        if (r_active == '0) begin
            act_n = N_W'(1);
        end else if (int'(r_active) > MAX_MACHINES) begin
            act_n = N_W'(MAX_MACHINES);
        end else begin
            act_n = N_W'(r_active);
        end
    end

    assign pos_inc   = N_W'(r_pos) + N_W'(1);
    assign last_iter = (N_W'(r_iter) == (r_n - N_W'(1)));
    assign rd_addr   = (r_state == ST_UPDATE) ? pick : r_pos;

    assign diff    = $signed({rd_cap[CAP_W-1], rd_cap})
                   - $signed({{(CAP_W + 1 - AMT_W){1'b0}}, r_amount});
    assign left    = (diff[CAP_W] != diff[CAP_W-1]) ? {1'b1, {(CAP_W - 1){1'b0}}}
                                                     : diff[CAP_W-1:0];
    assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active     <= ACTIVE_RESET;
            r_scan_start <= '0;
            r_n          <= N_W'(1);
            r_pos        <= '0;
            r_iter       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_scan_start <= n_scan_start;
            r_n          <= n_n;
            r_pos        <= n_pos;
            r_iter       <= n_iter;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_amount <= i_amount;
        end
        if (out_load) begin
            r_out_idx <= OUT_IDX_W'(pick);
            r_out_fit <= fit;
            r_out_cap <= left;
            r_out_cnt <= cnt_inc;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_scan_start   = r_scan_start;
        n_n            = r_n;
        n_pos          = r_pos;
        n_iter         = r_iter;
        n_out_valid    = r_out_valid && !out_take;
        out_load       = 1'b0;
        scan_ctl       = '0;
        bank_wr        = '0;
        bank_wr.addr   = pick;
        bank_wr.cap    = left;
        bank_wr.cnt    = cnt_inc;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_action == ACTION_JOB) begin
                        n_state        = ST_SCAN;
                        n_n            = act_n;
                        n_pos          = (N_W'(r_scan_start) < act_n) ? r_scan_start : '0;
                        n_iter         = '0;
                        scan_ctl.clear = 1'b1;
                    end else if (int'(i_machine_index) < MAX_MACHINES) begin
                        bank_wr.cap_we = 1'b1;
                        bank_wr.addr   = IDX_W'(i_machine_index);
                        bank_wr.cap    = $signed(CAP_W'(i_amount));
                    end
                end
            end
            ST_SCAN: begin
                scan_ctl.step = 1'b1;
                if (hit || last_iter) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_pos  = (pos_inc == r_n) ? '0 : pos_inc[IDX_W-1:0];
                    n_iter = r_iter + IDX_W'(1);
                end
            end
            ST_UPDATE: begin
                if (!r_out_valid || !i_out_stall) begin
                    bank_wr.cap_we = 1'b1;
                    bank_wr.cnt_we = 1'b1;
                    out_load       = 1'b1;
                    n_out_valid    = 1'b1;
                    n_scan_start   = pick;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_assigned_machine = r_out_idx;
    assign o_fitted           = r_out_fit;
    assign o_capacity_left    = r_out_cap;
    assign o_jobs_on_machine  = r_out_cnt;

endmodule

// ----- rtl/cffa_checker.sv -----
// Port-level checks for circular_first_fit_assign, attached by bind.
// Depends on cffa_pkg.
module cffa_checker
    import cffa_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    i_action,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [OUT_IDX_W-1:0]    o_assigned_machine,
    input logic                    o_fitted,
    input logic signed [CAP_W-1:0] o_capacity_left,
    input logic [CNT_W-1:0]        o_jobs_on_machine
);

    a_job_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action == ACTION_JOB)) |=> o_in_stall)
        else $error("job transaction did not make the block busy");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action == ACTION_LOAD)) |=> !$rose(o_out_valid))
        else $error("load transaction produced a result");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a job in progress");

    a_fit_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fitted) |-> !o_capacity_left[CAP_W-1])
        else $error("fitted job left a negative capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_assigned_machine)
            && $stable(o_fitted) && $stable(o_capacity_left) && $stable(o_jobs_on_machine)))
        else $error("stalled result changed");

endmodule

bind circular_first_fit_assign cffa_checker u_cffa_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .i_action           (i_action),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_assigned_machine (o_assigned_machine),
    .o_fitted           (o_fitted),
    .o_capacity_left    (o_capacity_left),
    .o_jobs_on_machine  (o_jobs_on_machine)
);

// ----- sim/cffa_check_pkg.sv -----
// Scoreboard for the circular first-fit assignment testbench: its own model of
// the machine bank and a queue of expected job assignments. Depends on cffa_pkg.
package cffa_check_pkg;

    import cffa_pkg::*;

    localparam longint CAP_FLOOR = -64'sd2147483648;
    localparam int     MAX_SHOWN = 50;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]    machine;
        logic                    fitted;
        logic signed [CAP_W-1:0] cap_left;
        logic [CNT_W-1:0]        jobs;
    } t_assignment;

    class assignment_scoreboard;
        logic signed [CAP_W-1:0] capacity [MAX_MACHINES];
        logic [CNT_W-1:0]        job_total [MAX_MACHINES];
        logic [IDX_W-1:0]        scan_from;
        logic [ACT_W-1:0]        active;
        t_assignment             expected_q [$];
        int                      errors;
        int                      results_seen;

        function new();
            active       = ACTIVE_RESET;
            scan_from    = '0;
            errors       = 0;
            results_seen = 0;
            foreach (capacity[i]) begin
                capacity[i]  = '0;
                job_total[i] = '0;
            end
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("mismatch at result %0d: %s", results_seen, msg);
        endtask

        function void note_config(input logic [ACT_W-1:0] value);
            active = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(input logic act, input logic [IDX_W-1:0] idx,
                                 input logic [AMT_W-1:0] amt);
            int unsigned n;
            int unsigned pos;
            int unsigned pick;
            longint      weight;
            longint      best;
            longint      c;
            longint      left;
            bit          fit;
            t_assignment res;
            if (act == ACTION_LOAD) begin
                capacity[idx] = CAP_W'(amt);
                return;
            end
            n = (active == 0) ? 1 : ((active > MAX_MACHINES) ? MAX_MACHINES : active);
            pos    = (scan_from < n) ? scan_from : 0;
            pick   = pos;
            best   = capacity[pos];
            weight = amt;
            fit    = 1'b0;
            for (int unsigned i = 0; i < n; i++) begin
                c = capacity[pos];
                if (weight <= c) begin
                    pick = pos;
                    fit  = 1'b1;
                    break;
                end
                if (c > best) begin
                    best = c;
                    pick = pos;
                end
                pos = (pos + 1 == n) ? 0 : pos + 1;
            end
            left = longint'(capacity[pick]) - weight;
            if (left < CAP_FLOOR)
                left = CAP_FLOOR;
            capacity[pick] = left[CAP_W-1:0];
            if (job_total[pick] != '1)
                job_total[pick] = job_total[pick] + 1'b1;
            scan_from = IDX_W'(pick);
            res.machine  = OUT_IDX_W'(pick);
            res.fitted   = fit;
            res.cap_left = capacity[pick];
            res.jobs     = job_total[pick];
            expected_q.push_back(res);
        endfunction

        task check_result(input t_assignment got);
            t_assignment want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected transaction, machine %0d", got.machine));
                return;
            end
            want = expected_q.pop_front();
            if (got.machine !== want.machine)
                report($sformatf("machine %0d, want %0d", got.machine, want.machine));
            if (got.fitted !== want.fitted)
                report($sformatf("fitted %0b, want %0b", got.fitted, want.fitted));
            if (got.cap_left !== want.cap_left)
                report($sformatf("capacity left %0d, want %0d", got.cap_left, want.cap_left));
            if (got.jobs !== want.jobs)
                report($sformatf("job count %0d, want %0d", got.jobs, want.jobs));
        endtask

        task close();
            while (expected_q.size() != 0) begin
                report($sformatf("missing transaction for machine %0d",
                                 expected_q[0].machine));
                void'(expected_q.pop_front());
            end
        endtask
    endclass

endpackage

// ----- sim/tb_top.sv -----
// Testbench for circular_first_fit_assign: directed jobs and random phases
// with idling and stalls. Depends on cffa_pkg and cffa_check_pkg.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cffa_pkg::*;
    import cffa_check_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 180;
    localparam int SETTLE       = 24;

    logic                    i_clk;
    logic                    rst_n         = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [ACT_W-1:0]        cfg_data      = '0;
    logic                    in_valid      = 1'b0;
    logic                    action        = ACTION_LOAD;
    logic [3:0]              machine_index = '0;
    logic [AMT_W-1:0]        amount        = '0;
    logic                    out_stall     = 1'b0;
    logic                    hold_off      = 1'b0;
    logic                    in_stall;
    logic                    out_valid;
    logic [OUT_IDX_W-1:0]    assigned_machine;
    logic                    fitted;
    logic signed [CAP_W-1:0] capacity_left;
    logic [CNT_W-1:0]        jobs_on_machine;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    event hold_off_ev;

    assignment_scoreboard assign_sb = new();

    circular_first_fit_assign dut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_action           (action),
        .i_machine_index    (machine_index),
        .i_amount           (amount),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_assigned_machine (assigned_machine),
        .o_fitted           (fitted),
        .o_capacity_left    (capacity_left),
        .o_jobs_on_machine  (jobs_on_machine)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        forever begin
            @(hold_off_ev);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (out_valid === 1'b1 && !out_stall)
                assign_sb.check_result(t_assignment'{assigned_machine, fitted,
                                                     capacity_left, jobs_on_machine});
            out_stall <= hold_off || ($urandom_range(99) < sink_stall_pct);
        end
    end

    function automatic logic [AMT_W-1:0] random_amount();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return AMT_W'($urandom_range(32'hFFFFFF) >> $urandom_range(16));
        endcase
    endfunction

    task automatic send(input logic act, input logic [3:0] idx, input logic [AMT_W-1:0] amt);
        if ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_valid      <= 1'b1;
        action        <= act;
        machine_index <= idx;
        amount        <= amt;
        do @(posedge i_clk); while (in_stall);
        assign_sb.note_input(act, idx, amt);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (assign_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_active(input logic [ACT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        assign_sb.note_config(value);
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        write_active(5'd16);
        send(ACTION_JOB, 4'd9, 24'h000000);
        send(ACTION_LOAD, 4'd0, 24'hFFFFFF);
        send(ACTION_LOAD, 4'd15, 24'h000100);
        send(ACTION_LOAD, 4'd7, 24'h800000);
        send(ACTION_JOB, 4'd0, 24'hFFFFFF);
        send(ACTION_JOB, 4'd15, 24'h900000);
        send(ACTION_JOB, 4'd5, 24'h000100);
        send(ACTION_JOB, 4'd10, 24'h000001);
        send(ACTION_JOB, 4'd3, 24'h000000);
        send(ACTION_LOAD, 4'd3, 24'h123456);
        send(ACTION_JOB, 4'd12, 24'h100000);
        send(ACTION_LOAD, 4'd10, 24'hFFFFFF);
        send(ACTION_JOB, 4'd6, 24'hFFFFF0);
        drain();
        // scan start sits above the new active count
        write_active(5'd4);
        send(ACTION_JOB, 4'd1, 24'h000005);
        send(ACTION_LOAD, 4'd2, 24'h0000FF);
        send(ACTION_JOB, 4'd11, 24'h0000FF);
        drain();
        write_active(5'd0);
        send(ACTION_JOB, 4'd14, 24'h000010);
        send(ACTION_JOB, 4'd5, 24'hAAAAAA);
        drain();
        write_active(5'd31);
        send(ACTION_LOAD, 4'd14, 24'h555555);
        send(ACTION_JOB, 4'd8, 24'h555555);
        drain();
    endtask

    task automatic run_phase(input logic [ACT_W-1:0] act_cfg, input int idle_pct,
                             input int stall_pct, input bit squeeze);
        logic [AMT_W-1:0] weight;
        int               pick;
        weight = '0;
        write_active(act_cfg);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        if (squeeze)
            -> hold_off_ev;
        repeat (PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 18) begin
                send(ACTION_LOAD, 4'($urandom_range(15)), random_amount());
            end else if (pick < 26) begin
                send(ACTION_JOB, 4'($urandom_range(15)), random_amount());
            end else begin
                if (weight == 0 || $urandom_range(15) == 0)
                    weight = random_amount();
                send(ACTION_JOB, 4'($urandom_range(15)), weight);
                weight = weight - AMT_W'($urandom_range(int'(weight >> 3)));
            end
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_phase(5'd16, 0, 0, 1'b0);
        run_phase(5'd3, 80, 0, 1'b0);
        run_phase(5'd0, 0, 80, 1'b0);
        run_phase(5'd31, 28, 28, 1'b0);
        run_phase(5'd1, 0, 0, 1'b0);
        run_phase(5'd8, 80, 0, 1'b0);
        run_phase(5'd17, 0, 80, 1'b0);
        run_phase(5'd2, 28, 28, 1'b0);
        run_phase(5'd12, 0, 0, 1'b1);
        run_phase(5'd16, 28, 28, 1'b0);
        repeat (SETTLE) @(posedge i_clk);
        assign_sb.close();
        if (assign_sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- circular_first_fit_assign.f -----
rtl/cffa_pkg.sv
rtl/cffa_bank.sv
rtl/cffa_scan.sv
rtl/circular_first_fit_assign.sv
rtl/cffa_checker.sv
sim/cffa_check_pkg.sv
sim/tb_top.sv
